[src/ffba_pkg.sv]
// Shared types, codes and default sizes of the flat file block allocator.
`default_nettype none

package ffba_pkg;

   // Default sizes handed to the top level parameters
   localparam int NUM_BLOCKS_DEF      = 128;
   localparam int NUM_SLOTS_DEF       = 16;
   localparam int MAX_FILE_BLOCKS_DEF = 8;

   // Payload field types
   typedef logic [1:0]  cmd_type;
   typedef logic [63:0] name_type;
   typedef logic [3:0]  count_type;
   typedef logic [2:0]  status_type;
   typedef logic [3:0]  slot_index_type;
   typedef logic [6:0]  disk_block_type;

   // Command codes
   localparam cmd_type CMD_CREATE = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_XLATE  = 2'd2;

   // Status codes
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_NO_SPACE  = 3'd1;
   localparam status_type ST_FULL      = 3'd2;
   localparam status_type ST_NOT_FOUND = 3'd3;
   localparam status_type ST_RANGE     = 3'd4;
   localparam status_type ST_TOO_LARGE = 3'd5;

endpackage

`default_nettype wire

[src/ffba_if.sv]
// Request and response channel interfaces of the flat file block allocator.
`default_nettype none

interface ffba_req_if;
   logic                      valid;
   logic                      ready;
   ffba_pkg::cmd_type         cmd;
   ffba_pkg::name_type        file_name;
   ffba_pkg::count_type       file_blocks;
   ffba_pkg::count_type       block_index;

   modport source (output valid, output cmd, output file_name, output file_blocks,
                   output block_index, input ready);
   modport sink   (input valid, input cmd, input file_name, input file_blocks,
                   input block_index, output ready);
endinterface

interface ffba_rsp_if;
   logic                      valid;
   logic                      ready;
   ffba_pkg::status_type      status;
   ffba_pkg::slot_index_type  slot_index;
   ffba_pkg::disk_block_type  disk_block;

   modport source (output valid, output status, output slot_index, output disk_block,
                   input ready);
   modport sink   (input valid, input status, input slot_index, input disk_block,
                   output ready);
endinterface

`default_nettype wire

[src/ffba_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none

module ffba_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

[src/ffba_ctrl.sv]
// Sequencer of the allocator: slot scan, block scan and pointer walk, one step at a time.
`default_nettype none

module ffba_ctrl #(
   parameter int NUM_BLOCKS      = ffba_pkg::NUM_BLOCKS_DEF,
   parameter int NUM_SLOTS       = ffba_pkg::NUM_SLOTS_DEF,
   parameter int MAX_FILE_BLOCKS = ffba_pkg::MAX_FILE_BLOCKS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ffba_req_if.sink              req_if,
   ffba_rsp_if.source            rsp_if,
   // block map memory
   output logic                  bm_wr_en,
   output logic [$clog2(NUM_BLOCKS)-1:0] bm_wr_addr,
   output logic                  bm_wr_data,
   output logic                  bm_rd_en,
   output logic [$clog2(NUM_BLOCKS)-1:0] bm_rd_addr,
   input  logic                  bm_rd_data,
   // slot name and size memory
   output logic                  sl_wr_en,
   output logic [$clog2(NUM_SLOTS)-1:0] sl_wr_addr,
   output logic [67:0]           sl_wr_data,
   output logic                  sl_rd_en,
   output logic [$clog2(NUM_SLOTS)-1:0] sl_rd_addr,
   input  logic [67:0]           sl_rd_data,
   // block pointer memory
   output logic                  pt_wr_en,
   output logic [$clog2(NUM_SLOTS*MAX_FILE_BLOCKS)-1:0] pt_wr_addr,
   output logic [$clog2(NUM_BLOCKS)-1:0] pt_wr_data,
   output logic                  pt_rd_en,
   output logic [$clog2(NUM_SLOTS*MAX_FILE_BLOCKS)-1:0] pt_rd_addr,
   input  logic [$clog2(NUM_BLOCKS)-1:0] pt_rd_data
);

   import ffba_pkg::*;

   localparam int BW  = $clog2(NUM_BLOCKS);
   localparam int SW  = $clog2(NUM_SLOTS);
   localparam int PAW = $clog2(NUM_SLOTS * MAX_FILE_BLOCKS);
   localparam int FCW = $clog2(NUM_BLOCKS + 1);

   // sequencer states
   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_SLOT_RD  = 4'd2;
   localparam logic [3:0] S_SLOT_CHK = 4'd3;
   localparam logic [3:0] S_BLK_RD   = 4'd4;
   localparam logic [3:0] S_BLK_CHK  = 4'd5;
   localparam logic [3:0] S_PTR_RD   = 4'd6;
   localparam logic [3:0] S_PTR_CHK  = 4'd7;
   localparam logic [3:0] S_FINISH   = 4'd8;

   logic [3:0]           state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   name_type             name_ff, name_in;
   count_type            size_ff, size_in;
   count_type            bidx_ff, bidx_in;
   logic [SW-1:0]        s_ff, s_in;
   logic [BW-1:0]        b_ff, b_in;
   count_type            i_ff, i_in;
   logic [FCW-1:0]       free_ff, free_in;
   logic [NUM_SLOTS-1:0] used_ff, used_in;
   status_type           res_status_ff, res_status_in;
   slot_index_type       res_slot_ff, res_slot_in;
   disk_block_type       res_disk_ff, res_disk_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   slot_index_type       rsp_slot_ff, rsp_slot_in;
   disk_block_type       rsp_disk_ff, rsp_disk_in;

   logic                 req_take;
   name_type             name_q;
   count_type            size_q;
   count_type            ptr_idx;
   logic [PAW-1:0]       ptr_addr;
   logic [SW+3:0]        slot_wide;
   logic [BW+6:0]        disk_wide;
   logic                 slot_last;
   logic                 blk_last;
   logic                 size_big;
   logic                 bidx_bad;
   logic                 alloc_done;
   logic                 free_done;

   assign req_if.ready      = (state_ff == S_IDLE);
   assign req_take          = req_if.valid && req_if.ready;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.slot_index = rsp_slot_ff;
   assign rsp_if.disk_block = rsp_disk_ff;

   // shared address and compare terms
   assign name_q     = sl_rd_data[67:4];
   assign size_q     = sl_rd_data[3:0];
   assign ptr_idx    = (cmd_ff == CMD_XLATE) ? bidx_ff : i_ff;
   assign ptr_addr   = PAW'(s_ff) * PAW'(MAX_FILE_BLOCKS) + PAW'(ptr_idx);
   assign slot_wide  = {4'd0, s_ff};
   assign disk_wide  = {7'd0, pt_rd_data};
   assign slot_last  = (s_ff == SW'(NUM_SLOTS - 1));
   assign blk_last   = (b_ff == BW'(NUM_BLOCKS - 1));
   assign size_big   = {1'b0, size_ff} > 5'(MAX_FILE_BLOCKS);
   assign bidx_bad   = ({1'b0, bidx_ff} >= {1'b0, size_q}) ||
                       ({1'b0, bidx_ff} >= 5'(MAX_FILE_BLOCKS));
   assign alloc_done = ({1'b0, i_ff} + 5'd1) == {1'b0, size_ff};
   assign free_done  = ({1'b0, i_ff} + 5'd1) == {1'b0, size_q};

   // memory port addresses follow the scan counters
   assign bm_rd_addr = b_ff;
   assign sl_rd_addr = s_ff;
   assign sl_wr_addr = s_ff;
   assign sl_wr_data = {name_ff, size_ff};
   assign pt_rd_addr = ptr_addr;
   assign pt_wr_addr = ptr_addr;
   assign pt_wr_data = b_ff;

   // next state and datapath
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      name_in       = name_ff;
      size_in       = size_ff;
      bidx_in       = bidx_ff;
      s_in          = s_ff;
      b_in          = b_ff;
      i_in          = i_ff;
      free_in       = free_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_disk_in   = res_disk_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_disk_in   = rsp_disk_ff;
      bm_wr_en      = 1'b0;
      bm_wr_addr    = b_ff;
      bm_wr_data    = 1'b1;
      bm_rd_en      = 1'b0;
      sl_wr_en      = 1'b0;
      sl_rd_en      = 1'b0;
      pt_wr_en      = 1'b0;
      pt_rd_en      = 1'b0;

      unique case (state_ff)
         // write the block map after reset: block 0 taken, others free
         S_INIT: begin
            bm_wr_en   = 1'b1;
            bm_wr_data = (b_ff == '0);
            b_in       = b_ff + BW'(1);
            if (blk_last) begin
               b_in     = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               cmd_in      = req_if.cmd;
               name_in     = req_if.file_name;
               size_in     = req_if.file_blocks;
               bidx_in     = req_if.block_index;
               s_in        = '0;
               b_in        = '0;
               i_in        = '0;
               res_slot_in = '0;
               res_disk_in = '0;
               unique case (req_if.cmd)
                  CMD_CREATE: begin
                     if (free_ff < FCW'(req_if.file_blocks)) begin
                        res_status_in = ST_NO_SPACE;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_SLOT_RD;
                     end
                  end
                  CMD_DELETE, CMD_XLATE: begin
                     state_in = S_SLOT_RD;
                  end
                  default: begin
                     res_status_in = ST_NOT_FOUND;
                     state_in      = S_FINISH;
                  end
               endcase
            end
         end
         S_SLOT_RD: begin
            sl_rd_en = 1'b1;
            state_in = S_SLOT_CHK;
         end
         // one slot per visit: free slot for create, name match otherwise
         S_SLOT_CHK: begin
            if (cmd_ff == CMD_CREATE) begin
               if (!used_ff[s_ff]) begin
                  if (size_big) begin
                     res_status_in = ST_TOO_LARGE;
                     state_in      = S_FINISH;
                  end else begin
                     sl_wr_en      = 1'b1;
                     used_in[s_ff] = 1'b1;
                     res_status_in = ST_OK;
                     res_slot_in   = slot_wide[3:0];
                     state_in      = (size_ff == '0) ? S_FINISH : S_BLK_RD;
                  end
               end else if (slot_last) begin
                  res_status_in = ST_FULL;
                  state_in      = S_FINISH;
               end else begin
                  s_in     = s_ff + SW'(1);
                  state_in = S_SLOT_RD;
               end
            end else begin
               if (used_ff[s_ff] && (name_q == name_ff)) begin
                  res_slot_in = slot_wide[3:0];
                  if (cmd_ff == CMD_DELETE) begin
                     if (size_q == '0) begin
                        used_in[s_ff] = 1'b0;
                        res_status_in = ST_OK;
                        state_in      = S_FINISH;
                     end else begin
                        state_in = S_PTR_RD;
                     end
                  end else if (bidx_bad) begin
                     res_status_in = ST_RANGE;
                     state_in      = S_FINISH;
                  end else begin
                     state_in = S_PTR_RD;
                  end
               end else if (slot_last) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_FINISH;
               end else begin
                  s_in     = s_ff + SW'(1);
                  state_in = S_SLOT_RD;
               end
            end
         end
         S_BLK_RD: begin
            bm_rd_en = 1'b1;
            state_in = S_BLK_CHK;
         end
         // first fit: take a free block, record its pointer
         S_BLK_CHK: begin
            b_in     = b_ff + BW'(1);
            state_in = S_BLK_RD;
            if (!bm_rd_data) begin
               bm_wr_en = 1'b1;
               pt_wr_en = 1'b1;
               free_in  = free_ff - FCW'(1);
               i_in     = i_ff + 4'd1;
               if (alloc_done) begin
                  state_in = S_FINISH;
               end
            end
            if (blk_last) begin
               state_in = S_FINISH;
            end
         end
         S_PTR_RD: begin
            pt_rd_en = 1'b1;
            state_in = S_PTR_CHK;
         end
         // translate returns the pointer, delete frees it
         S_PTR_CHK: begin
            if (cmd_ff == CMD_XLATE) begin
               res_status_in = ST_OK;
               res_disk_in   = disk_wide[6:0];
               state_in      = S_FINISH;
            end else begin
               if (pt_rd_data != '0) begin
                  bm_wr_en   = 1'b1;
                  bm_wr_addr = pt_rd_data;
                  bm_wr_data = 1'b0;
                  free_in    = free_ff + FCW'(1);
               end
               i_in = i_ff + 4'd1;
               if (free_done) begin
                  used_in[s_ff] = 1'b0;
                  res_status_in = ST_OK;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_PTR_RD;
               end
            end
         end
         // move the result into the output register once it is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_disk_in   = res_disk_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         b_ff         <= '0;
         free_ff      <= FCW'(NUM_BLOCKS - 1);
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b_ff         <= b_in;
         free_ff      <= free_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      name_ff       <= name_in;
      size_ff       <= size_in;
      bidx_ff       <= bidx_in;
      s_ff          <= s_in;
      i_ff          <= i_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_disk_ff   <= res_disk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_disk_ff   <= rsp_disk_in;
   end

endmodule

`default_nettype wire

[src/flat_file_block_allocator.sv]
// Top level of the flat file block allocator: sequencer and its three memories.
//
//   channel  direction  handshake      payload
//   req_if   in         valid / ready  cmd, file_name, file_blocks, block_index
//   rsp_if   out        valid / ready  status, slot_index, disk_block
//
// One item at a time; every step of the sequencer is a memory read then a check.
// Per item the sequencer reads and checks each slot visited, then each block map entry
// visited (create) or each pointer of the file (delete); translate adds the pointer read.
// After reset every block map entry is written before req_if.ready rises.
// A finished result waits in the output register; the next item is taken meanwhile.
`default_nettype none

module flat_file_block_allocator #(
   parameter int NUM_BLOCKS      = ffba_pkg::NUM_BLOCKS_DEF,
   parameter int NUM_SLOTS       = ffba_pkg::NUM_SLOTS_DEF,
   parameter int MAX_FILE_BLOCKS = ffba_pkg::MAX_FILE_BLOCKS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ffba_req_if.sink   req_if,
   ffba_rsp_if.source rsp_if
);

   import ffba_pkg::*;

   localparam int BW  = $clog2(NUM_BLOCKS);
   localparam int SW  = $clog2(NUM_SLOTS);
   localparam int PAW = $clog2(NUM_SLOTS * MAX_FILE_BLOCKS);

   logic           bm_wr_en, bm_wr_data, bm_rd_en, bm_rd_data;
   logic [BW-1:0]  bm_wr_addr, bm_rd_addr;
   logic           sl_wr_en, sl_rd_en;
   logic [SW-1:0]  sl_wr_addr, sl_rd_addr;
   logic [67:0]    sl_wr_data, sl_rd_data;
   logic           pt_wr_en, pt_rd_en;
   logic [PAW-1:0] pt_wr_addr, pt_rd_addr;
   logic [BW-1:0]  pt_wr_data, pt_rd_data;

   // sequencer
   ffba_ctrl #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .NUM_SLOTS       (NUM_SLOTS),
      .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .rsp_if     (rsp_if),
      .bm_wr_en   (bm_wr_en),
      .bm_wr_addr (bm_wr_addr),
      .bm_wr_data (bm_wr_data),
      .bm_rd_en   (bm_rd_en),
      .bm_rd_addr (bm_rd_addr),
      .bm_rd_data (bm_rd_data),
      .sl_wr_en   (sl_wr_en),
      .sl_wr_addr (sl_wr_addr),
      .sl_wr_data (sl_wr_data),
      .sl_rd_en   (sl_rd_en),
      .sl_rd_addr (sl_rd_addr),
      .sl_rd_data (sl_rd_data),
      .pt_wr_en   (pt_wr_en),
      .pt_wr_addr (pt_wr_addr),
      .pt_wr_data (pt_wr_data),
      .pt_rd_en   (pt_rd_en),
      .pt_rd_addr (pt_rd_addr),
      .pt_rd_data (pt_rd_data)
   );

   // block in-use map, one bit per block
   ffba_ram #(
      .DEPTH (NUM_BLOCKS),
      .WIDTH (1)
   ) u_block_map (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_en   (bm_rd_en),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   // slot name and size
   ffba_ram #(
      .DEPTH (NUM_SLOTS),
      .WIDTH (68)
   ) u_slot_mem (
      .clock   (clock),
      .wr_en   (sl_wr_en),
      .wr_addr (sl_wr_addr),
      .wr_data (sl_wr_data),
      .rd_en   (sl_rd_en),
      .rd_addr (sl_rd_addr),
      .rd_data (sl_rd_data)
   );

   // block pointers, MAX_FILE_BLOCKS per slot
   ffba_ram #(
      .DEPTH (NUM_SLOTS * MAX_FILE_BLOCKS),
      .WIDTH (BW)
   ) u_ptr_mem (
      .clock   (clock),
      .wr_en   (pt_wr_en),
      .wr_addr (pt_wr_addr),
      .wr_data (pt_wr_data),
      .rd_en   (pt_rd_en),
      .rd_addr (pt_rd_addr),
      .rd_data (pt_rd_data)
   );

endmodule

`default_nettype wire

[bench/flat_file_block_allocator_tb.sv]
// Self-checking testbench of the flat file block allocator: directed and random file traffic.
`timescale 1ns / 1ps

module flat_file_block_allocator_tb;
   import ffba_pkg::*;

   localparam int NB  = NUM_BLOCKS_DEF;
   localparam int NS  = NUM_SLOTS_DEF;
   localparam int MFB = MAX_FILE_BLOCKS_DEF;

   // Cycles with no handshake on either channel before the run is abandoned
   localparam int WATCHDOG_LIMIT = 5000;
   // Receiver hold-off used to back the block up
   localparam int RSP_HOLD_CYCLES = 400;
   // Quiet cycles after the last response
   localparam int DRAIN_CYCLES = 400;
   localparam int NAME_POOL = 12;

   // Unused command code
   localparam cmd_type CMD_UNUSED = 2'd3;

   typedef struct packed {
      status_type     status;
      slot_index_type slot;
      disk_block_type block;
   } file_result_type;

   logic clock;
   logic reset;

   ffba_req_if req_ch ();
   ffba_rsp_if rsp_ch ();

   flat_file_block_allocator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Shadow of the allocator state
   bit       map_used  [NB];
   int       free_left;
   bit       slot_live [NS];
   name_type slot_nm   [NS];
   int       slot_len  [NS];
   int       slot_ptr  [NS][MFB];

   file_result_type expected_q[$];
   name_type        name_pool[NAME_POOL];

   int  errors;
   int  items_sent;
   int  results_seen;
   int  status_seen[8];
   bit  steady;
   bit  rsp_hold_req;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Lowest used slot holding this name, or -1
   function automatic int find_file(name_type nm);
      for (int s = 0; s < NS; s++)
         if (slot_live[s] && slot_nm[s] == nm) return s;
      return -1;
   endfunction

   // Work out the response to one request and update the shadow state
   function automatic file_result_type predict_file_op(cmd_type c, name_type nm, count_type nb,
                                                       count_type bi);
      file_result_type r;
      int s;
      int b;
      int p;
      r = '{status: ST_NOT_FOUND, slot: '0, block: '0};
      case (c)
         CMD_CREATE: begin
            s = 0;
            while (s < NS && slot_live[s]) s++;
            if (free_left < int'(nb)) begin
               r.status = ST_NO_SPACE;
            end else if (s >= NS) begin
               r.status = ST_FULL;
            end else if (int'(nb) > MFB) begin
               r.status = ST_TOO_LARGE;
            end else begin
               slot_live[s] = 1'b1;
               slot_nm[s]   = nm;
               slot_len[s]  = nb;
               b = 0;
               for (int i = 0; i < int'(nb); i++) begin
                  while (b < NB && map_used[b]) b++;
                  if (b >= NB) break;
                  map_used[b] = 1'b1;
                  free_left--;
                  slot_ptr[s][i] = b;
               end
               r.status = ST_OK;
               r.slot   = slot_index_type'(s);
            end
         end
         CMD_DELETE: begin
            s = find_file(nm);
            if (s >= 0) begin
               for (int i = 0; i < slot_len[s] && i < MFB; i++) begin
                  p = slot_ptr[s][i];
                  if (p != 0 && p < NB && map_used[p]) begin
                     map_used[p] = 1'b0;
                     free_left++;
                  end
               end
               slot_live[s] = 1'b0;
               r.status = ST_OK;
               r.slot   = slot_index_type'(s);
            end
         end
         CMD_XLATE: begin
            s = find_file(nm);
            if (s >= 0) begin
               r.slot = slot_index_type'(s);
               if (int'(bi) >= slot_len[s] || int'(bi) >= MFB) begin
                  r.status = ST_RANGE;
               end else begin
                  r.status = ST_OK;
                  r.block  = disk_block_type'(slot_ptr[s][bi]);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic name_type random_name();
      return {$urandom(), $urandom()};
   endfunction

   // Name of a random live file, or a pool name when nothing is live
   function automatic name_type pick_live_name();
      int live;
      int k;
      live = 0;
      for (int s = 0; s < NS; s++) live += slot_live[s];
      if (live == 0) return name_pool[$urandom_range(NAME_POOL - 1)];
      k = $urandom_range(live - 1);
      for (int s = 0; s < NS; s++) begin
         if (slot_live[s]) begin
            if (k == 0) return slot_nm[s];
            k--;
         end
      end
      return name_pool[0];
   endfunction

   // Offer one item, wait until it is taken, then record its expected response
   task automatic send_item(cmd_type c, name_type nm, count_type nb, count_type bi);
      while (!steady && $urandom_range(99) < 30) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= c;
      req_ch.file_name   <= nm;
      req_ch.file_blocks <= nb;
      req_ch.block_index <= bi;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_q.push_back(predict_file_op(c, nm, nb, bi));
      items_sent++;
   endtask

   // Every command, field extremes, duplicates, zero size and block reuse
   task automatic test_directed_ops();
      name_type nx;
      name_type ny;
      nx = random_name();
      ny = ~nx;
      send_item(CMD_CREATE, '1, 4'd0, 4'd0);
      send_item(CMD_XLATE, '1, 4'd0, 4'd0);
      send_item(CMD_CREATE, '0, 4'd8, 4'd15);
      send_item(CMD_XLATE, '0, 4'd0, 4'd0);
      send_item(CMD_XLATE, '0, 4'd0, 4'd7);
      send_item(CMD_XLATE, '0, 4'd0, 4'd8);
      send_item(CMD_XLATE, '0, 4'd0, 4'd15);
      send_item(CMD_CREATE, nx, 4'd15, 4'd0);
      send_item(CMD_CREATE, nx, 4'd9, 4'd0);
      send_item(CMD_UNUSED, nx, 4'd15, 4'd15);
      send_item(CMD_DELETE, nx, 4'd0, 4'd0);
      send_item(CMD_XLATE, nx, 4'd0, 4'd0);
      // duplicate names act on the lowest matching slot
      send_item(CMD_CREATE, nx, 4'd1, 4'd0);
      send_item(CMD_CREATE, nx, 4'd2, 4'd0);
      send_item(CMD_XLATE, nx, 4'd0, 4'd0);
      send_item(CMD_DELETE, nx, 4'd0, 4'd0);
      send_item(CMD_XLATE, nx, 4'd0, 4'd1);
      send_item(CMD_DELETE, '1, 4'd0, 4'd0);
      // freed blocks come back lowest first
      send_item(CMD_CREATE, ny, 4'd3, 4'd0);
      send_item(CMD_XLATE, ny, 4'd0, 4'd2);
      send_item(CMD_DELETE, '0, 4'd0, 4'd0);
      send_item(CMD_DELETE, nx, 4'd0, 4'd0);
      send_item(CMD_DELETE, ny, 4'd0, 4'd0);
   endtask

   // Use up the disk and the table, then empty both
   task automatic test_exhaustion();
      name_type nm[NS];
      for (int i = 0; i < NS; i++) nm[i] = random_name();
      for (int i = 0; i < NS - 1; i++) send_item(CMD_CREATE, nm[i], 4'd8, 4'd0);
      send_item(CMD_CREATE, nm[NS-1], 4'd8, 4'd0);
      send_item(CMD_CREATE, nm[NS-1], 4'd7, 4'd0);
      send_item(CMD_CREATE, random_name(), 4'd0, 4'd0);
      send_item(CMD_CREATE, random_name(), 4'd1, 4'd0);
      send_item(CMD_CREATE, random_name(), 4'd15, 4'd0);
      send_item(CMD_XLATE, nm[NS-1], 4'd0, 4'd6);
      for (int i = 0; i < NS; i++) send_item(CMD_DELETE, nm[i], 4'd0, 4'd0);
   endtask

   // Hold the receiver off while requests keep coming
   task automatic test_output_backpressure();
      rsp_hold_req = 1'b1;
      send_item(CMD_CREATE, name_pool[0], 4'd4, 4'd0);
      for (int i = 0; i < 12; i++)
         send_item(CMD_XLATE, name_pool[0], count_type'($urandom_range(5)), 4'd0);
      send_item(CMD_DELETE, name_pool[0], 4'd0, 4'd0);
   endtask

   // Random traffic biased toward filling up or draining the allocator
   task automatic test_random_traffic(int n_items, bit filling);
      int        r;
      int        pc;
      int        pd;
      cmd_type   c;
      name_type  nm;
      count_type nb;
      count_type bi;
      pc = filling ? 55 : 15;
      pd = filling ? 15 : 50;
      for (int n = 0; n < n_items; n++) begin
         r  = $urandom_range(99);
         nb = count_type'($urandom_range(15));
         bi = count_type'($urandom_range(15));
         if (r < pc) begin
            c  = CMD_CREATE;
            nm = ($urandom_range(99) < 80) ? name_pool[$urandom_range(NAME_POOL - 1)]
                                           : random_name();
            r  = $urandom_range(99);
            if (!filling)   nb = count_type'($urandom_range(MFB));
            else if (r < 70) nb = count_type'($urandom_range(MFB, MFB - 1));
            else if (r < 90) nb = count_type'($urandom_range(MFB - 2));
         end else if (r < pc + pd) begin
            c  = CMD_DELETE;
            nm = pick_live_name();
         end else if (r < 90) begin
            c  = CMD_XLATE;
            nm = pick_live_name();
            if ($urandom_range(99) < 80) bi = count_type'($urandom_range(MFB + 1));
         end else begin
            // noise: unknown names and the unused command code
            c  = cmd_type'($urandom_range(3));
            if (c == CMD_CREATE) c = CMD_UNUSED;
            nm = random_name();
         end
         send_item(c, nm, nb, bi);
      end
   endtask

   // Receiver ready, with random gaps and an occasional long hold-off
   initial begin : rsp_ready_gen
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            hold_left    = RSP_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 30);
         end
      end
   end

   // Compare each response with the oldest expectation
   always @(posedge clock) begin : check_rsp
      file_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: response with none expected: status %0d slot %0d block %0d",
                     $time, rsp_ch.status, rsp_ch.slot_index, rsp_ch.disk_block);
         end else begin
            want = expected_q.pop_front();
            status_seen[want.status]++;
            if (rsp_ch.status !== want.status) begin
               errors++;
               $display("%0t: status mismatch: expected %0d actual %0d",
                        $time, want.status, rsp_ch.status);
            end
            if (rsp_ch.slot_index !== want.slot) begin
               errors++;
               $display("%0t: slot_index mismatch: expected %0d actual %0d",
                        $time, want.slot, rsp_ch.slot_index);
            end
            if (rsp_ch.disk_block !== want.block) begin
               errors++;
               $display("%0t: disk_block mismatch: expected %0d actual %0d",
                        $time, want.block, rsp_ch.disk_block);
            end
         end
      end
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin : watchdog
      int quiet;
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                  $time, quiet, expected_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Main sequence
   initial begin
      reset              = 1'b1;
      steady             = 1'b0;
      rsp_hold_req       = 1'b0;
      errors             = 0;
      items_sent         = 0;
      results_seen       = 0;
      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_CREATE;
      req_ch.file_name   = '0;
      req_ch.file_blocks = '0;
      req_ch.block_index = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (map_used[i]) map_used[i] = 1'b0;
      map_used[0] = 1'b1;
      free_left   = NB - 1;
      foreach (slot_live[i]) begin
         slot_live[i] = 1'b0;
         slot_nm[i]   = '0;
         slot_len[i]  = 0;
      end
      foreach (slot_ptr[i, j]) slot_ptr[i][j] = 0;
      foreach (name_pool[i]) name_pool[i] = random_name();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_exhaustion();
      test_output_backpressure();
      for (int p = 0; p < 12; p++) begin
         steady = (p == 4);
         test_random_traffic(150, p % 2 == 0);
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests and %0d responses: ok %0d, no space %0d, table full %0d,",
               items_sent, results_seen, status_seen[ST_OK], status_seen[ST_NO_SPACE],
               status_seen[ST_FULL]);
      $display("  not found %0d, index out of range %0d, size too large %0d",
               status_seen[ST_NOT_FOUND], status_seen[ST_RANGE], status_seen[ST_TOO_LARGE]);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
